// ===== design/assert_macros.svh =====
// Assertion macros shared by the frequency counter RTL.
// Included by every module that carries concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication check failed");

// Next-cycle implication, checked outside reset.
`define ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// ===== design/gfc_pkg.sv =====
// Shared constants, register codes and interface structs of the frequency counter.
// Used by gfc_window, gfc_divbcd and the top level; no dependencies.
package gfc_pkg;

  localparam int HISTORY_DEPTH = 10;
  localparam int DIGITS        = 8;

  localparam int CNT_W   = 16;
  localparam int TOL_W   = 8;
  localparam int FILL_W  = $clog2(HISTORY_DEPTH + 1);
  localparam int SUM_W   = CNT_W + $clog2(HISTORY_DEPTH);
  localparam int DIV_W   = SUM_W + 4;
  localparam int REM_W   = FILL_W + 1;
  localparam int STEP_W  = $clog2(DIV_W);
  localparam int BCD_W   = 4 * DIGITS;
  localparam int MEAN_W  = 23;
  localparam int DOUT_W  = 32;
  localparam int MASK_W  = 8;
  localparam int ADDR_W  = 3;
  localparam int DATA_W  = 32;

  localparam logic [CNT_W-1:0] GATE_TICKS_RST = 16'd1000;
  localparam logic [TOL_W-1:0] TOLERANCE_RST  = 8'd1;
  localparam logic [CNT_W-1:0] COUNT_MAX      = '1;

  // Register index codes (byte address 4 * index).
  localparam logic REG_GATE_TICKS = 1'b0;
  localparam logic REG_TOLERANCE  = 1'b1;

  // Window close request from the front end to the arithmetic back end.
  typedef struct packed {
    logic              start;
    logic [CNT_W-1:0]  reading;
    logic [FILL_W-1:0] fill;
    logic [SUM_W-1:0]  sum;
    logic              stable;
  } gfc_req_t;

  typedef struct packed {
    logic [CNT_W-1:0]  latest_count;
    logic [FILL_W-1:0] readings_held;
    logic [MEAN_W-1:0] mean_tenths;
    logic [DOUT_W-1:0] bcd_digits;
    logic [MASK_W-1:0] blank_mask;
    logic              stable;
  } gfc_res_t;

endpackage

// ===== design/gfc_window.sv =====
// Front end: edge and gate tick counters, reading history and running sum.
// Depends on gfc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module gfc_window (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      fire,
  input  logic                      edge_seen,
  input  logic                      gate_tick,
  input  logic [gfc_pkg::CNT_W-1:0] gate_ticks,
  input  logic [gfc_pkg::TOL_W-1:0] tolerance,
  output gfc_pkg::gfc_req_t         req
);
  import gfc_pkg::*;

  logic [CNT_W-1:0]  edge_count_r, edge_count_nxt;
  logic [CNT_W-1:0]  tick_count_r, tick_count_nxt;
  logic [CNT_W-1:0]  hist_r [HISTORY_DEPTH];
  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic [SUM_W-1:0]  sum_r, sum_nxt;
  logic [CNT_W-1:0]  edge_inc;
  logic [CNT_W-1:0]  tick_inc;
  logic [CNT_W-1:0]  oldest;
  logic [CNT_W-1:0]  diff;
  logic              close;

  always_comb begin
    edge_inc = (edge_seen && edge_count_r != COUNT_MAX) ? edge_count_r + 1'b1 : edge_count_r;
    tick_inc = tick_count_r + 1'b1;
    close    = fire && gate_tick && (tick_inc >= gate_ticks);

    edge_count_nxt = edge_count_r;
    tick_count_nxt = tick_count_r;
    if (fire) begin
      edge_count_nxt = close ? '0 : edge_inc;
      if (gate_tick) begin
        tick_count_nxt = close ? '0 : tick_inc;
      end
    end

    sum_nxt  = sum_r - SUM_W'(hist_r[0]) + SUM_W'(edge_inc);
    fill_nxt = (fill_r == FILL_W'(HISTORY_DEPTH)) ? fill_r : fill_r + 1'b1;

    // After the shift the oldest slot is the one that is second oldest now.
    oldest = hist_r[1];
    diff   = (oldest > edge_inc) ? oldest - edge_inc : edge_inc - oldest;

    req.start   = close;
    req.reading = edge_inc;
    req.fill    = fill_nxt;
    req.sum     = sum_nxt;
    req.stable  = (diff <= CNT_W'(tolerance));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      edge_count_r <= '0;
      tick_count_r <= '0;
      fill_r       <= '0;
      sum_r        <= '0;
      for (int i = 0; i < HISTORY_DEPTH; i++) begin
        hist_r[i] <= '0;
      end
    end else begin
      edge_count_r <= edge_count_nxt;
      tick_count_r <= tick_count_nxt;
      if (close) begin
        fill_r <= fill_nxt;
        sum_r  <= sum_nxt;
        for (int i = 0; i < HISTORY_DEPTH - 1; i++) begin
          hist_r[i] <= hist_r[i + 1];
        end
        hist_r[HISTORY_DEPTH - 1] <= edge_inc;
      end
    end
  end

  `ASSERT_IMP(a_fill_bound, clk, rst_n, 1'b1, fill_r <= FILL_W'(HISTORY_DEPTH))
  `ASSERT_NXT(a_close_clears, clk, rst_n, close, edge_count_r == '0 && tick_count_r == '0)
  `ASSERT_IMP(a_close_fill, clk, rst_n, close, req.fill != '0)

endmodule

// ===== design/gfc_divbcd.sv =====
// Back end: multi-cycle mean division, binary to BCD conversion and result register.
// Depends on gfc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module gfc_divbcd (
  input  logic              clk,
  input  logic              rst_n,
  input  gfc_pkg::gfc_req_t req,
  output logic              idle,
  output logic              out_valid,
  input  logic              out_ready,
  output gfc_pkg::gfc_res_t res
);
  import gfc_pkg::*;

  typedef enum logic [1:0] {ST_IDLE, ST_DIVIDE, ST_CONVERT, ST_FINISH} state_t;

  state_t            state_r, state_nxt;
  logic [DIV_W-1:0]  acc_r, acc_nxt;
  logic [REM_W-1:0]  rem_r, rem_nxt;
  logic [FILL_W-1:0] div_r, div_nxt;
  logic [BCD_W-1:0]  bcd_r, bcd_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [CNT_W-1:0]  reading_r, reading_nxt;
  logic              stable_r, stable_nxt;
  logic [MEAN_W-1:0] mean_r, mean_nxt;
  logic              out_valid_r, out_valid_nxt;
  gfc_res_t          res_r, res_nxt;

  logic [REM_W-1:0]  trial;
  logic              qbit;
  logic [BCD_W-1:0]  bcd_adj;
  logic [DIGITS-1:0] mask;
  logic              lead;
  logic              last_step;

  always_comb begin
    // Restoring divide step: one quotient bit per cycle.
    trial = {rem_r[REM_W-2:0], acc_r[DIV_W-1]};
    qbit  = (trial >= {1'b0, div_r});

    // Double-dabble correction on every digit before the shift.
    for (int i = 0; i < DIGITS; i++) begin
      bcd_adj[4*i +: 4] = (bcd_r[4*i +: 4] >= 4'd5) ? bcd_r[4*i +: 4] + 4'd3
                                                     : bcd_r[4*i +: 4];
    end

    // A digit is blanked while every digit above it, and itself, is zero.
    lead = 1'b1;
    for (int i = DIGITS - 1; i >= 0; i--) begin
      lead    = lead && (bcd_r[4*i +: 4] == 4'd0);
      mask[i] = lead;
    end

    last_step = (step_r == STEP_W'(DIV_W - 1));

    state_nxt     = state_r;
    acc_nxt       = acc_r;
    rem_nxt       = rem_r;
    div_nxt       = div_r;
    bcd_nxt       = bcd_r;
    step_nxt      = step_r;
    reading_nxt   = reading_r;
    stable_nxt    = stable_r;
    mean_nxt      = mean_r;
    out_valid_nxt = out_valid_r && !out_ready;
    res_nxt       = res_r;

    case (state_r)
      ST_IDLE: begin
        if (req.start) begin
          // Sum times ten as two shifted copies.
          acc_nxt     = DIV_W'({req.sum, 3'b000}) + DIV_W'({req.sum, 1'b0});
          rem_nxt     = '0;
          div_nxt     = req.fill;
          step_nxt    = '0;
          reading_nxt = req.reading;
          stable_nxt  = req.stable;
          state_nxt   = ST_DIVIDE;
        end
      end
      ST_DIVIDE: begin
        rem_nxt  = qbit ? trial - {1'b0, div_r} : trial;
        acc_nxt  = {acc_r[DIV_W-2:0], qbit};
        step_nxt = step_r + 1'b1;
        if (last_step) begin
          mean_nxt  = MEAN_W'(acc_nxt);
          bcd_nxt   = '0;
          step_nxt  = '0;
          state_nxt = ST_CONVERT;
        end
      end
      ST_CONVERT: begin
        bcd_nxt  = {bcd_adj[BCD_W-2:0], acc_r[DIV_W-1]};
        acc_nxt  = {acc_r[DIV_W-2:0], 1'b0};
        step_nxt = step_r + 1'b1;
        if (last_step) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        // Wait here until the result register is free or being emptied.
        if (!out_valid_r || out_ready) begin
          res_nxt.latest_count  = reading_r;
          res_nxt.readings_held = div_r;
          res_nxt.mean_tenths   = mean_r;
          res_nxt.bcd_digits    = DOUT_W'(bcd_r);
          res_nxt.blank_mask    = MASK_W'(mask);
          res_nxt.stable        = stable_r;
          out_valid_nxt         = 1'b1;
          state_nxt             = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    acc_r     <= acc_nxt;
    rem_r     <= rem_nxt;
    div_r     <= div_nxt;
    bcd_r     <= bcd_nxt;
    step_r    <= step_nxt;
    reading_r <= reading_nxt;
    stable_r  <= stable_nxt;
    mean_r    <= mean_nxt;
    res_r     <= res_nxt;
  end

  assign idle      = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign res       = res_r;

  `ASSERT_IMP(a_start_when_idle, clk, rst_n, req.start, state_r == ST_IDLE)
  `ASSERT_IMP(a_rem_below_div, clk, rst_n, state_r == ST_DIVIDE, rem_r < {1'b0, div_r})
  `ASSERT_IMP(a_divisor_nonzero, clk, rst_n, state_r == ST_DIVIDE, div_r != '0)
  `ASSERT_IMP(a_result_held, clk, rst_n, out_valid_r, res_r.readings_held != '0)

endmodule

// ===== design/gated_frequency_counter_avg.sv =====
// Gated frequency counter with a moving average. An input transfer that does not
// close a measurement window leaves the block ready. A transfer that closes a
// window holds in_ready low while the back end works. During that time one shared
// shift datapath first divides ten times the history sum by the readings held (one
// quotient bit per cycle). It then converts the mean to BCD (one bit per cycle), and
// a final state moves the result into the output register. out_valid and in_ready
// rise in the same cycle. A finished result waits in the output register without
// blocking new input transfers. If it is still waiting when the next window's
// result is ready, the block stays busy, with in_ready low, until the receiver
// takes it.
// Registers: gate_ticks at address 0, stable_tolerance at address 4.
// Depends on gfc_pkg, gfc_window and gfc_divbcd.
module gated_frequency_counter_avg (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        in_edge_seen,
  input  logic                        in_gate_tick,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [15:0]                 out_latest_count,
  output logic [3:0]                  out_readings_held,
  output logic [22:0]                 out_mean_tenths,
  output logic [31:0]                 out_bcd_digits,
  output logic [7:0]                  out_blank_mask,
  output logic                        out_stable,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [gfc_pkg::ADDR_W-1:0]  paddr,
  input  logic [gfc_pkg::DATA_W-1:0]  pwdata,
  output logic [gfc_pkg::DATA_W-1:0]  prdata,
  output logic                        pready
);
  import gfc_pkg::*;

  logic [CNT_W-1:0] gate_ticks_r;
  logic [TOL_W-1:0] tolerance_r;
  logic             reg_idx;
  logic             fire;
  logic             be_idle;
  gfc_req_t         req;
  gfc_res_t         res;

  assign reg_idx = paddr[2];
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gate_ticks_r <= GATE_TICKS_RST;
      tolerance_r  <= TOLERANCE_RST;
    end else if (psel && penable && pwrite) begin
      case (reg_idx)
        REG_GATE_TICKS: gate_ticks_r <= pwdata[CNT_W-1:0];
        REG_TOLERANCE:  tolerance_r  <= pwdata[TOL_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_GATE_TICKS: prdata = DATA_W'(gate_ticks_r);
      REG_TOLERANCE:  prdata = DATA_W'(tolerance_r);
      default:        prdata = '0;
    endcase
  end

  assign in_ready = be_idle;
  assign fire     = in_valid && in_ready;

  gfc_window u_window (
    .clk        (clk),
    .rst_n      (rst_n),
    .fire       (fire),
    .edge_seen  (in_edge_seen),
    .gate_tick  (in_gate_tick),
    .gate_ticks (gate_ticks_r),
    .tolerance  (tolerance_r),
    .req        (req)
  );

  gfc_divbcd u_divbcd (
    .clk       (clk),
    .rst_n     (rst_n),
    .req       (req),
    .idle      (be_idle),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .res       (res)
  );

  assign out_latest_count  = res.latest_count;
  assign out_readings_held = res.readings_held;
  assign out_mean_tenths   = res.mean_tenths;
  assign out_bcd_digits    = res.bcd_digits;
  assign out_blank_mask    = res.blank_mask;
  assign out_stable        = res.stable;

endmodule

// ===== tb/sv/gated_frequency_counter_avg_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for gated_frequency_counter_avg: sends sample transfers and
// register writes, predicts each closed window and checks every result transfer.
// Depends on gfc_pkg and the gated_frequency_counter_avg RTL.
module gated_frequency_counter_avg_tb;
  import gfc_pkg::*;

  localparam int DRAIN_CYCLES = 64;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  logic              in_edge_seen;
  logic              in_gate_tick;
  logic              out_valid;
  logic              out_ready;
  logic [15:0]       out_latest_count;
  logic [3:0]        out_readings_held;
  logic [22:0]       out_mean_tenths;
  logic [31:0]       out_bcd_digits;
  logic [7:0]        out_blank_mask;
  logic              out_stable;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  gated_frequency_counter_avg DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_edge_seen     (in_edge_seen),
    .in_gate_tick     (in_gate_tick),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_latest_count (out_latest_count),
    .out_readings_held(out_readings_held),
    .out_mean_tenths  (out_mean_tenths),
    .out_bcd_digits   (out_bcd_digits),
    .out_blank_mask   (out_blank_mask),
    .out_stable       (out_stable),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  // Shadow of the counter state and its registers.
  logic [CNT_W-1:0] gate_cfg = GATE_TICKS_RST;
  logic [TOL_W-1:0] tol_cfg  = TOLERANCE_RST;
  logic [CNT_W-1:0] win_edges = '0;
  logic [CNT_W-1:0] win_ticks = '0;
  logic [CNT_W-1:0] reading_hist [HISTORY_DEPTH] = '{default: '0};
  int unsigned      readings_in = 0;
  int unsigned      hist_sum = 0;

  gfc_res_t pending_results [$];
  int       mismatch_count = 0;

  bit tx_burst = 1'b0;
  bit rx_steady = 1'b0;
  int rx_hold_cycles = 0;

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Applies one sample to the shadow state; returns 1 when it closes a window.
  function automatic bit tally_sample(input bit edge_bit, input bit tick_bit,
                                      output gfc_res_t res);
    logic [CNT_W-1:0] reading;
    logic [31:0]      bcd;
    logic [7:0]       mask;
    int unsigned      mean_v;
    int unsigned      rest;
    int unsigned      diff;
    bit               lead;
    int               i;
    res = '0;
    if (edge_bit && win_edges != COUNT_MAX) win_edges = win_edges + 1'b1;
    if (!tick_bit) return 1'b0;
    win_ticks = win_ticks + 1'b1;
    if (win_ticks < gate_cfg) return 1'b0;

    reading   = win_edges;
    win_edges = '0;
    win_ticks = '0;
    hist_sum  = hist_sum - reading_hist[0];
    for (i = 0; i < HISTORY_DEPTH - 1; i++) reading_hist[i] = reading_hist[i + 1];
    reading_hist[HISTORY_DEPTH - 1] = reading;
    hist_sum = hist_sum + reading;
    if (readings_in < HISTORY_DEPTH) readings_in++;

    mean_v = (hist_sum * 10) / readings_in;
    bcd  = '0;
    rest = mean_v;
    for (i = 0; i < DIGITS; i++) begin
      bcd[4*i +: 4] = 4'(rest % 10);
      rest = rest / 10;
    end
    // Leading zero digits are blanked from the top down, the tenths digit included.
    mask = '0;
    lead = 1'b1;
    for (i = DIGITS - 1; i >= 0; i--) begin
      if (bcd[4*i +: 4] != 4'd0) lead = 1'b0;
      if (lead) mask[i] = 1'b1;
    end
    diff = (reading_hist[0] > reading_hist[HISTORY_DEPTH - 1]) ?
           reading_hist[0] - reading_hist[HISTORY_DEPTH - 1] :
           reading_hist[HISTORY_DEPTH - 1] - reading_hist[0];

    res.latest_count  = reading;
    res.readings_held = readings_in[FILL_W-1:0];
    res.mean_tenths   = mean_v[MEAN_W-1:0];
    res.bcd_digits    = bcd;
    res.blank_mask    = mask;
    res.stable        = (diff <= tol_cfg);
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (mismatch_count < 40) begin
      $display("ERROR at %0t ns: %s got 0x%0h, wanted 0x%0h", $time, what, got, want);
    end
    mismatch_count++;
  endtask

  always @(posedge clk) begin
    gfc_res_t want;
    if (rst_n === 1'b1 && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result transfer with nothing pending", 32'(out_latest_count),
                        32'd0);
      end else begin
        want = pending_results.pop_front();
        if (out_latest_count !== want.latest_count)
          report_mismatch("latest_count", 32'(out_latest_count), 32'(want.latest_count));
        if (out_readings_held !== want.readings_held)
          report_mismatch("readings_held", 32'(out_readings_held),
                          32'(want.readings_held));
        if (out_mean_tenths !== want.mean_tenths)
          report_mismatch("mean_tenths", 32'(out_mean_tenths), 32'(want.mean_tenths));
        if (out_bcd_digits !== want.bcd_digits)
          report_mismatch("bcd_digits", out_bcd_digits, want.bcd_digits);
        if (out_blank_mask !== want.blank_mask)
          report_mismatch("blank_mask", 32'(out_blank_mask), 32'(want.blank_mask));
        if (out_stable !== want.stable)
          report_mismatch("stable", 32'(out_stable), 32'(want.stable));
      end
    end
  end

  // Result side: a random stall before each transfer, or a long hold when requested.
  initial begin
    int stall;
    out_ready <= 1'b0;
    @(posedge clk);
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      if (rx_hold_cycles > 0) begin
        stall = rx_hold_cycles;
        rx_hold_cycles = 0;
      end else begin
        stall = rx_steady ? 0 : $urandom_range(0, 8);
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
    end
  end

  task automatic send_sample(input bit edge_bit, input bit tick_bit);
    gfc_res_t res;
    int       gap;
    gap = tx_burst ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_edge_seen <= edge_bit;
    in_gate_tick <= tick_bit;
    do @(posedge clk); while (!in_ready);
    if (tally_sample(edge_bit, tick_bit, res)) pending_results.push_back(res);
  endtask

  task automatic send_window(input int n_edges, input int n_ticks);
    int i;
    for (i = 0; i < n_edges; i++) send_sample(1'b1, 1'b0);
    for (i = 0; i < n_ticks; i++) send_sample(1'b0, 1'b1);
  endtask

  // Waits for every pending result, then lets the back end finish any late work.
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic reg_code, input logic [DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_code, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (reg_code == REG_GATE_TICKS) gate_cfg = value[CNT_W-1:0];
    else tol_cfg = value[TOL_W-1:0];
  endtask

  // Upper data bits are don't-care and get random values.
  task automatic configure(input logic [CNT_W-1:0] gate, input logic [TOL_W-1:0] tol);
    settle();
    write_reg(REG_GATE_TICKS, {16'($urandom), gate});
    write_reg(REG_TOLERANCE, {24'($urandom), tol});
  endtask

  // Samples at the reset gate length: the window stays open and its edges carry over.
  task automatic test_reset_values();
    int n;
    tx_burst = 1'b1;
    for (n = 0; n < 20; n++) send_sample(1'($urandom_range(0, 1)), 1'b1);
    tx_burst = 1'b0;
  endtask

  task automatic test_directed();
    // Zero gate length acts like one: every tick closes a window.
    configure(16'd0, 8'd0);
    send_sample(1'b0, 1'b1);
    send_sample(1'b1, 1'b1);
    send_sample(1'b1, 1'b0);
    send_sample(1'b1, 1'b0);
    send_sample(1'b0, 1'b0);
    send_sample(1'b1, 1'b1);
    configure(16'd3, 8'd1);
    send_sample(1'b1, 1'b0);
    send_sample(1'b0, 1'b1);
    send_sample(1'b1, 1'b1);
    send_sample(1'b0, 1'b0);
    send_sample(1'b1, 1'b1);
    // Shortening the gate mid-window closes it on the next tick.
    configure(16'd5, 8'd2);
    send_sample(1'b1, 1'b1);
    send_sample(1'b0, 1'b1);
    send_sample(1'b1, 1'b1);
    configure(16'd2, 8'd2);
    send_sample(1'b1, 1'b1);
    send_sample(1'b0, 1'b1);
    send_sample(1'b0, 1'b1);
  endtask

  task automatic test_random_traffic();
    int phase;
    int n;
    int edge_pct;
    int tick_pct;
    logic [CNT_W-1:0] gate;
    logic [TOL_W-1:0] tol;
    for (phase = 0; phase < 7; phase++) begin
      gate = (phase == 0) ? 16'd1 : 16'($urandom_range(1, 8));
      tol  = (phase == 1) ? 8'd0 : (phase == 2) ? 8'd255 : 8'($urandom_range(0, 3));
      configure(gate, tol);
      tx_burst  = (phase == 3);
      rx_steady = (phase == 3);
      edge_pct  = $urandom_range(10, 90);
      tick_pct  = $urandom_range(20, 80);
      for (n = 0; n < 50; n++) begin
        send_sample($urandom_range(0, 99) < edge_pct, $urandom_range(0, 99) < tick_pct);
        if (phase == 4 && n == 25) settle();
      end
      tx_burst  = 1'b0;
      rx_steady = 1'b0;
    end
  endtask

  // The receiver holds off long enough for results to back up into the input.
  task automatic test_output_stall();
    int n;
    configure(16'd1, 8'd1);
    rx_hold_cycles = 400;
    tx_burst = 1'b1;
    for (n = 0; n < 40; n++) send_sample(1'($urandom_range(0, 1)), 1'b1);
    tx_burst = 1'b0;
  endtask

  // An oldest-to-newest difference at or just past the widest tolerance.
  task automatic test_wide_readings();
    configure(16'd1, 8'd255);
    tx_burst = 1'b1;
    send_window(0, 1);
    send_window(256, 1);
    tx_burst = 1'b0;
  endtask

  initial begin
    rst_n        <= 1'b0;
    in_valid     <= 1'b0;
    in_edge_seen <= 1'b0;
    in_gate_tick <= 1'b0;
    psel         <= 1'b0;
    penable      <= 1'b0;
    pwrite       <= 1'b0;
    paddr        <= '0;
    pwdata       <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_values();
    test_directed();
    test_random_traffic();
    test_output_stall();
    test_wide_readings();

    settle();
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+design
design/gfc_pkg.sv
design/gfc_window.sv
design/gfc_divbcd.sv
design/gated_frequency_counter_avg.sv
tb/sv/gated_frequency_counter_avg_tb.sv
